// ===== rtl/tcwc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcwc_pkg
// Shared widths, codes and control types of the congestion window block.
// ----------------------------------------------------------------------------
package tcwc_pkg;

  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;
  localparam int DUP_W      = 16;
  localparam int MSS_W      = 16;
  localparam int ISEG_W     = 5;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // serial unit: steps per operation and counter width
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [DUP_W-1:0]  DUP_FAST = DUP_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_DUP     = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_OPEN     = 2'd0,
    PH_LOSS     = 2'd1,
    PH_RECOVERY = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RENO = 2'd0,
    CFG_MSS  = 2'd1,
    CFG_ISEG = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic              start;
    md_op_t            op;
    logic [WORD_W-1:0] a;   // multiplicand or dividend
    logic [WORD_W-1:0] b;   // multiplier (low bits) or divisor
  } md_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } md_sts_t;

endpackage

// ===== rtl/tcwc_if.sv =====
// ----------------------------------------------------------------------------
// tcwc channel interfaces
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tcwc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcwc_pkg::MODE_W-1:0]   mode;
  logic [tcwc_pkg::WORD_W-1:0]   ack_len;
  logic [tcwc_pkg::DUP_W-1:0]    dup_count;
  logic [tcwc_pkg::WORD_W-1:0]   timeout_flight;
  logic [tcwc_pkg::WORD_W-1:0]   next_seq;
  logic [tcwc_pkg::WORD_W-1:0]   oldest_unacked;

  modport source (output valid, mode, ack_len, dup_count, timeout_flight,
                  next_seq, oldest_unacked, input ready);
  modport sink   (input valid, mode, ack_len, dup_count, timeout_flight,
                  next_seq, oldest_unacked, output ready);
endinterface

interface tcwc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcwc_pkg::WORD_W-1:0]   window_bytes;
  logic [tcwc_pkg::WORD_W-1:0]   threshold_bytes;
  logic [tcwc_pkg::PHASE_W-1:0]  phase;
  logic                          retransmit_oldest;
  logic                          rewind_send;
  logic                          send_more;

  modport source (output valid, window_bytes, threshold_bytes, phase,
                  retransmit_oldest, rewind_send, send_more, input ready);
  modport sink   (input valid, window_bytes, threshold_bytes, phase,
                  retransmit_oldest, rewind_send, send_more, output ready);
endinterface

interface tcwc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcwc_pkg::CFG_IDX_W-1:0]  index;
  logic [tcwc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tcwc_muldiv.sv =====
// ----------------------------------------------------------------------------
// tcwc_muldiv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module tcwc_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  tcwc_pkg::md_cmd_t cmd_i,
  output tcwc_pkg::md_sts_t sts_o
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  tcwc_pkg::md_op_t                op_r, op_nxt;
  logic [tcwc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  // x: product accumulator or partial remainder
  // y: shifted multiplicand, or dividend shifting out as quotient shifts in
  logic [tcwc_pkg::WORD_W-1:0]     x_r, x_nxt;
  logic [tcwc_pkg::WORD_W-1:0]     y_r, y_nxt;
  logic [tcwc_pkg::MSS_W-1:0]      z_r, z_nxt;
  logic [tcwc_pkg::WORD_W-1:0]     d_r, d_nxt;
  logic [tcwc_pkg::WORD_W:0]       trial;
  logic [tcwc_pkg::WORD_W:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    d_nxt    = d_r;
    trial    = {x_r, y_r[tcwc_pkg::WORD_W-1]};
    diff     = trial - {1'b0, d_r};

    if (cmd_i.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd_i.op;
      x_nxt    = '0;
      y_nxt    = cmd_i.a;
      z_nxt    = cmd_i.b[tcwc_pkg::MSS_W-1:0];
      d_nxt    = cmd_i.b;
      cnt_nxt  = (cmd_i.op == tcwc_pkg::MD_MUL) ?
                 tcwc_pkg::CNT_W'(tcwc_pkg::MUL_STEPS - 1) :
                 tcwc_pkg::CNT_W'(tcwc_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      case (op_r)
        tcwc_pkg::MD_MUL: begin
          x_nxt = x_r + (z_r[0] ? y_r : '0);
          y_nxt = {y_r[tcwc_pkg::WORD_W-2:0], 1'b0};
          z_nxt = {1'b0, z_r[tcwc_pkg::MSS_W-1:1]};
        end
        tcwc_pkg::MD_DIV: begin
          // subtract when the trial remainder covers the divisor
          if (!diff[tcwc_pkg::WORD_W]) begin
            x_nxt = diff[tcwc_pkg::WORD_W-1:0];
            y_nxt = {y_r[tcwc_pkg::WORD_W-2:0], 1'b1};
          end else begin
            x_nxt = trial[tcwc_pkg::WORD_W-1:0];
            y_nxt = {y_r[tcwc_pkg::WORD_W-2:0], 1'b0};
          end
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= tcwc_pkg::MD_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    d_r <= d_nxt;
  end

  assign sts_o.busy   = busy_r;
  assign sts_o.done   = done_r;
  assign sts_o.result = (op_r == tcwc_pkg::MD_MUL) ? x_r : y_r;

endmodule

// ===== rtl/tcw_control_top_placeholder_unused.sv =====
// ----------------------------------------------------------------------------
// tcwc_flag_check
// Watch on the result register: at most one action flag, each only with its matching phase.
// ----------------------------------------------------------------------------
module tcwc_flag_check (
  input logic             clk,
  input logic             rst_n,
  input logic             valid,
  input tcwc_pkg::phase_t phase,
  input logic             retx,
  input logic             rewind,
  input logic             more
);

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    valid |-> $onehot0({retx, rewind, more}))
    else $error("more than one action flag raised");

  a_retx_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (valid && retx) |-> (phase == tcwc_pkg::PH_LOSS))
    else $error("retransmit without loss phase");

  a_rewind_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (valid && (rewind || more)) |-> (phase == tcwc_pkg::PH_RECOVERY))
    else $error("recovery flag outside fast recovery");

endmodule

// ===== rtl/tcp_congestion_window_control.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_control
// Tahoe / Reno congestion window, slow-start threshold and phase tracker.
// ----------------------------------------------------------------------------
// One event is worked on at a time. An init event runs a multiply, a
// congestion-avoidance ACK a multiply and then a divide (the divide is skipped
// and the window saturates when the window is zero), and every other event goes
// from the execute state straight to done; the input is ready again from the
// edge that loads the result. The steps use the shared serial unit: a shift-add
// multiplier at one bit per cycle (for the segment size products) and a
// restoring divider at one quotient bit per cycle (for segment_size^2 /
// window), each then reporting done. The result register lets the next event
// be taken while a result still waits downstream. Configuration writes are
// always accepted; write them between events, and they apply from the next.
module tcp_congestion_window_control (
  input  logic        clk,
  input  logic        rst_n,
  tcwc_in_if.sink     in_ch,
  tcwc_out_if.source  out_ch,
  tcwc_cfg_if.sink    cfg_ch
);

  localparam int W = tcwc_pkg::WORD_W;

  tcwc_pkg::state_t             state_r, state_nxt;
  logic                         reno_r;
  logic [tcwc_pkg::MSS_W-1:0]   mss_r;
  logic [tcwc_pkg::ISEG_W-1:0]  iseg_r;

  logic [W-1:0]                 window_r, window_nxt;
  logic [W-1:0]                 thresh_r, thresh_nxt;
  tcwc_pkg::phase_t             phase_r, phase_nxt;
  logic                         retx_r, retx_nxt;
  logic                         rewind_r, rewind_nxt;
  logic                         more_r, more_nxt;

  tcwc_pkg::mode_t              mode_r;
  logic [W-1:0]                 acked_r;
  logic [tcwc_pkg::DUP_W-1:0]   dup_r;
  logic [W-1:0]                 flight_r;

  logic                         out_valid_r;
  logic [W-1:0]                 out_window_r;
  logic [W-1:0]                 out_thresh_r;
  tcwc_pkg::phase_t             out_phase_r;
  logic                         out_retx_r, out_rewind_r, out_more_r;

  tcwc_pkg::md_cmd_t            md_cmd;
  tcwc_pkg::md_sts_t            md_sts;

  logic                         in_fire;
  logic                         out_load;
  logic [W-1:0]                 loss_thr;
  logic [W-1:0]                 mss_x3;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
                                           input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? tcwc_pkg::ALL_ONES : s[W-1:0];
  endfunction

  assign in_ch.ready  = (state_r == tcwc_pkg::ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == tcwc_pkg::ST_DONE) &&
                        (!out_valid_r || out_ch.ready);

  // max(flight / 2, 2 * MSS)
  always_comb begin
    if ({1'b0, flight_r[W-1:1]} > W'({mss_r, 1'b0})) begin
      loss_thr = {1'b0, flight_r[W-1:1]};
    end else begin
      loss_thr = W'({mss_r, 1'b0});
    end
  end

  assign mss_x3 = W'({mss_r, 1'b0}) + W'(mss_r);

  always_comb begin
    state_nxt  = state_r;
    window_nxt = window_r;
    thresh_nxt = thresh_r;
    phase_nxt  = phase_r;
    retx_nxt   = retx_r;
    rewind_nxt = rewind_r;
    more_nxt   = more_r;
    md_cmd     = '{start: 1'b0, op: tcwc_pkg::MD_MUL, a: '0, b: '0};

    case (state_r)
      tcwc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = tcwc_pkg::ST_EXEC;
        end
      end

      tcwc_pkg::ST_EXEC: begin
        retx_nxt   = 1'b0;
        rewind_nxt = 1'b0;
        more_nxt   = 1'b0;
        state_nxt  = tcwc_pkg::ST_DONE;
        case (mode_r)
          tcwc_pkg::MODE_INIT: begin
            thresh_nxt = tcwc_pkg::ALL_ONES;
            phase_nxt  = tcwc_pkg::PH_OPEN;
            md_cmd     = '{start: 1'b1, op: tcwc_pkg::MD_MUL,
                           a: W'(mss_r), b: W'(iseg_r)};
            state_nxt  = tcwc_pkg::ST_MUL;
          end
          tcwc_pkg::MODE_ACK: begin
            if (reno_r && phase_r == tcwc_pkg::PH_RECOVERY) begin
              // deflate on leaving fast recovery
              window_nxt = thresh_r;
              phase_nxt  = tcwc_pkg::PH_OPEN;
            end else begin
              if (!reno_r) begin
                phase_nxt = tcwc_pkg::PH_OPEN;
              end
              if (window_r < thresh_r) begin
                window_nxt = sat_add(window_r, acked_r);
              end else begin
                md_cmd    = '{start: 1'b1, op: tcwc_pkg::MD_MUL,
                              a: W'(mss_r), b: W'(mss_r)};
                state_nxt = tcwc_pkg::ST_MUL;
              end
            end
          end
          tcwc_pkg::MODE_DUP: begin
            if (!reno_r) begin
              if (dup_r == tcwc_pkg::DUP_FAST) begin
                thresh_nxt = loss_thr;
                window_nxt = W'(mss_r);
                phase_nxt  = tcwc_pkg::PH_LOSS;
                retx_nxt   = 1'b1;
              end
            end else if (dup_r == tcwc_pkg::DUP_FAST) begin
              thresh_nxt = loss_thr;
              window_nxt = sat_add(loss_thr, mss_x3);
              phase_nxt  = tcwc_pkg::PH_RECOVERY;
              rewind_nxt = 1'b1;
            end else if (dup_r > tcwc_pkg::DUP_FAST &&
                         phase_r == tcwc_pkg::PH_RECOVERY) begin
              window_nxt = sat_add(window_r, W'(mss_r));
              more_nxt   = 1'b1;
            end
          end
          default: begin
            thresh_nxt = loss_thr;
            window_nxt = W'(mss_r);
            phase_nxt  = tcwc_pkg::PH_LOSS;
          end
        endcase
      end

      tcwc_pkg::ST_MUL: begin
        if (md_sts.done) begin
          if (mode_r == tcwc_pkg::MODE_INIT) begin
            window_nxt = md_sts.result;
            state_nxt  = tcwc_pkg::ST_DONE;
          end else if (window_r == '0) begin
            // zero divisor: all-ones quotient saturates the sum
            window_nxt = tcwc_pkg::ALL_ONES;
            state_nxt  = tcwc_pkg::ST_DONE;
          end else begin
            md_cmd    = '{start: 1'b1, op: tcwc_pkg::MD_DIV,
                          a: md_sts.result, b: window_r};
            state_nxt = tcwc_pkg::ST_DIV;
          end
        end
      end

      tcwc_pkg::ST_DIV: begin
        if (md_sts.done) begin
          window_nxt = sat_add(window_r, md_sts.result);
          state_nxt  = tcwc_pkg::ST_DONE;
        end
      end

      tcwc_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = tcwc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcwc_pkg::ST_IDLE;
      window_r    <= '0;
      thresh_r    <= tcwc_pkg::ALL_ONES;
      phase_r     <= tcwc_pkg::PH_OPEN;
      retx_r      <= 1'b0;
      rewind_r    <= 1'b0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      phase_r     <= phase_nxt;
      retx_r      <= retx_nxt;
      rewind_r    <= rewind_nxt;
      more_r      <= more_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reno_r <= 1'b1;
      mss_r  <= tcwc_pkg::MSS_W'(1460);
      iseg_r <= tcwc_pkg::ISEG_W'(10);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tcwc_pkg::CFG_RENO: reno_r <= cfg_ch.data[0];
        tcwc_pkg::CFG_MSS:  mss_r  <= cfg_ch.data[tcwc_pkg::MSS_W-1:0];
        tcwc_pkg::CFG_ISEG: iseg_r <= cfg_ch.data[tcwc_pkg::ISEG_W-1:0];
        default: begin
          reno_r <= reno_r;
        end
      endcase
    end
  end

  // latch the event; pick the flight that a loss would use
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= tcwc_pkg::mode_t'(in_ch.mode);
      acked_r <= in_ch.ack_len;
      dup_r   <= in_ch.dup_count;
      if (tcwc_pkg::mode_t'(in_ch.mode) == tcwc_pkg::MODE_TIMEOUT) begin
        flight_r <= in_ch.timeout_flight;
      end else begin
        flight_r <= in_ch.next_seq - in_ch.oldest_unacked;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_window_r <= window_r;
      out_thresh_r <= thresh_r;
      out_phase_r  <= phase_r;
      out_retx_r   <= retx_r;
      out_rewind_r <= rewind_r;
      out_more_r   <= more_r;
    end
  end

  tcwc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (md_cmd),
    .sts_o (md_sts)
  );

  tcwc_flag_check u_flag_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid  (out_valid_r),
    .phase  (out_phase_r),
    .retx   (out_retx_r),
    .rewind (out_rewind_r),
    .more   (out_more_r)
  );

  assign out_ch.valid             = out_valid_r;
  assign out_ch.window_bytes      = out_window_r;
  assign out_ch.threshold_bytes   = out_thresh_r;
  assign out_ch.phase             = out_phase_r;
  assign out_ch.retransmit_oldest = out_retx_r;
  assign out_ch.rewind_send       = out_rewind_r;
  assign out_ch.send_more         = out_more_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("event taken while previous one in progress");

  a_unit_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_sts.done |-> (state_r == tcwc_pkg::ST_MUL || state_r == tcwc_pkg::ST_DIV))
    else $error("serial unit finished outside a wait state");

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !md_sts.busy)
    else $error("serial unit busy while taking an event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=>
      (out_valid_r && $stable(out_window_r) && $stable(out_thresh_r)))
    else $error("waiting result changed");

endmodule
